// ===== hw/rtl/pmas_pkg.sv =====
`default_nettype none

package pmas_pkg;

	localparam int FIELD_BITS  = 16;
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] x_coord;
		logic signed [FIELD_BITS-1:0] y_coord;
		logic                         last_point;
	} point_in_t;

	typedef struct packed {
		logic signed [FIELD_BITS-1:0] x_out;
		logic signed [FIELD_BITS-1:0] y_out;
		logic                         last_out;
		logic                         overflowed;
	} point_out_t;

	typedef enum logic [1:0] {
		RANK_LOWER = 2'd0,
		RANK_ZERO  = 2'd1,
		RANK_UPPER = 2'd2,
		RANK_PI    = 2'd3
	} rank_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pmas_front.sv =====
`default_nettype none

module pmas_front #(
	parameter int CW = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  point_valid,
	output logic                  point_stall,
	input  pmas_pkg::point_in_t   point,
	input  pmas_pkg::q_status_t   q_status,
	output logic                  push,
	output logic [4*CW+2:0]       entry
);
	import pmas_pkg::*;

	localparam int EW = (CW > FIELD_BITS) ? CW : FIELD_BITS;

	logic [EW-1:0]          ext_x;
	logic [EW-1:0]          ext_y;
	logic signed [CW-1:0]   px;
	logic signed [CW-1:0]   py;
	logic signed [2*CW-1:0] sq_x;
	logic signed [2*CW-1:0] sq_y;
	logic [2*CW-1:0]        mag;
	rank_t                  rank;
	logic                   accept;

	logic                   valid_s1;
	logic signed [CW-1:0]   x_s1;
	logic signed [CW-1:0]   y_s1;
	logic [2*CW-1:0]        mag_s1;
	rank_t                  rank_s1;
	logic                   last_s1;

	assign ext_x = EW'($unsigned(point.x_coord));
	assign ext_y = EW'($unsigned(point.y_coord));
	assign px    = signed'(ext_x[CW-1:0]);
	assign py    = signed'(ext_y[CW-1:0]);
	assign sq_x  = px * px;
	assign sq_y  = py * py;
	assign mag   = $unsigned(sq_x) + $unsigned(sq_y);

	always_comb begin
		if (py < 0) begin
			rank = RANK_LOWER;
		end else if (py == 0) begin
			rank = (px >= 0) ? RANK_ZERO : RANK_PI;
		end else begin
			rank = RANK_UPPER;
		end
	end

	assign point_stall = valid_s1 && q_status.full;
	assign accept      = point_valid && !point_stall;
	assign push        = valid_s1 && !q_status.full;
	assign entry       = {last_s1, rank_s1, mag_s1, y_s1, x_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= px;
			y_s1    <= py;
			mag_s1  <= mag;
			rank_s1 <= rank;
			last_s1 <= point.last_point;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pmas_queue.sv =====
`default_nettype none

module pmas_queue #(
	parameter int WIDTH = 67
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    entry,
	input  logic                pop,
	output logic [WIDTH-1:0]    head,
	output pmas_pkg::q_status_t q_status
);
	import pmas_pkg::*;

	localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slots_q [QUEUE_DEPTH];
	logic [PTRW-1:0]  wr_q;
	logic [PTRW-1:0]  rd_q;
	logic [CNTW-1:0]  count_q;

	assign head           = slots_q[rd_q];
	assign q_status.full  = count_q == CNTW'(QUEUE_DEPTH);
	assign q_status.empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= entry;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pmas_cell.sv =====
`default_nettype none

module pmas_cell #(
	parameter int CW = 16
) (
	input  logic                  clk,
	input  logic                  occupied,
	input  logic                  load,
	input  logic                  shift,
	input  logic                  left_flag,
	input  logic signed [CW-1:0]  new_x,
	input  logic signed [CW-1:0]  new_y,
	input  logic [2*CW-1:0]       new_mag,
	input  pmas_pkg::rank_t       new_rank,
	input  logic signed [CW-1:0]  left_x,
	input  logic signed [CW-1:0]  left_y,
	input  logic [2*CW-1:0]       left_mag,
	input  pmas_pkg::rank_t       left_rank,
	input  logic signed [CW-1:0]  right_x,
	input  logic signed [CW-1:0]  right_y,
	input  logic [2*CW-1:0]       right_mag,
	input  pmas_pkg::rank_t       right_rank,
	output logic signed [CW-1:0]  x,
	output logic signed [CW-1:0]  y,
	output logic [2*CW-1:0]       mag,
	output pmas_pkg::rank_t       rank,
	output logic                  flag
);
	import pmas_pkg::*;

	logic signed [2*CW-1:0] cross_a;
	logic signed [2*CW-1:0] cross_b;
	logic                   mag_lt;
	logic                   mag_eq;
	logic                   rank_lt;
	logic                   rank_eq;
	logic                   on_arc;
	logic                   goes_first;

	assign cross_a    = new_x * y;
	assign cross_b    = new_y * x;
	assign mag_lt     = new_mag < mag;
	assign mag_eq     = new_mag == mag;
	assign rank_lt    = new_rank < rank;
	assign rank_eq    = new_rank == rank;
	assign on_arc     = (rank == RANK_LOWER) || (rank == RANK_UPPER);
	assign goes_first = mag_lt ||
		(mag_eq && (rank_lt || (rank_eq && on_arc && (cross_a > cross_b))));
	assign flag       = !occupied || goes_first;

	always_ff @(posedge clk) begin
		if (shift) begin
			x    <= right_x;
			y    <= right_y;
			mag  <= right_mag;
			rank <= right_rank;
		end else if (load && flag) begin
			if (left_flag) begin
				x    <= left_x;
				y    <= left_y;
				mag  <= left_mag;
				rank <= left_rank;
			end else begin
				x    <= new_x;
				y    <= new_y;
				mag  <= new_mag;
				rank <= new_rank;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pmas_back.sv =====
`default_nettype none

module pmas_back #(
	parameter int MAX_POINTS = 64,
	parameter int CW         = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pmas_pkg::q_status_t   q_status,
	input  logic [4*CW+2:0]       head,
	output logic                  pop,
	output logic                  result_valid,
	input  logic                  result_stall,
	output pmas_pkg::point_out_t  result
);
	import pmas_pkg::*;

	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int EW   = (CW > FIELD_BITS) ? CW : FIELD_BITS;

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} back_state_t;

	back_state_t          state_q;
	logic [CNTW-1:0]      count_q;
	logic                 drop_q;

	logic signed [CW-1:0] nx;
	logic signed [CW-1:0] ny;
	logic [2*CW-1:0]      nmag;
	rank_t                nrank;
	logic                 nlast;
	logic                 full;
	logic                 load;
	logic                 shift;
	logic [EW-1:0]        out_x;
	logic [EW-1:0]        out_y;

	logic signed [CW-1:0] cx    [MAX_POINTS];
	logic signed [CW-1:0] cy    [MAX_POINTS];
	logic [2*CW-1:0]      cmag  [MAX_POINTS];
	rank_t                crank [MAX_POINTS];
	logic [MAX_POINTS-1:0] flags;
	logic [MAX_POINTS-1:0] occ;

	assign nx    = head[CW-1:0];
	assign ny    = head[2*CW-1:CW];
	assign nmag  = head[4*CW-1:2*CW];
	assign nrank = rank_t'(head[4*CW+1:4*CW]);
	assign nlast = head[4*CW+2];

	assign full         = count_q == CNTW'(MAX_POINTS);
	assign pop          = (state_q == ST_LOAD) && !q_status.empty;
	assign load         = pop && !full;
	assign result_valid = state_q == ST_DRAIN;
	assign shift        = result_valid && !result_stall;

	assign out_x             = EW'($unsigned(cx[0]));
	assign out_y             = EW'($unsigned(cy[0]));
	assign result.x_out      = out_x[FIELD_BITS-1:0];
	assign result.y_out      = out_y[FIELD_BITS-1:0];
	assign result.last_out   = count_q == CNTW'(1);
	assign result.overflowed = drop_q;

	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		logic signed [CW-1:0] lx;
		logic signed [CW-1:0] ly;
		logic [2*CW-1:0]      lmag;
		rank_t                lrank;
		logic                 lflag;
		logic signed [CW-1:0] rx;
		logic signed [CW-1:0] ry;
		logic [2*CW-1:0]      rmag;
		rank_t                rrank;

		assign occ[i] = CNTW'(i) < count_q;

		if (i == 0) begin : g_first
			assign lx    = nx;
			assign ly    = ny;
			assign lmag  = nmag;
			assign lrank = nrank;
			assign lflag = 1'b0;
		end else begin : g_inner
			assign lx    = cx[i-1];
			assign ly    = cy[i-1];
			assign lmag  = cmag[i-1];
			assign lrank = crank[i-1];
			assign lflag = flags[i-1];
		end

		if (i == MAX_POINTS - 1) begin : g_last
			assign rx    = cx[i];
			assign ry    = cy[i];
			assign rmag  = cmag[i];
			assign rrank = crank[i];
		end else begin : g_mid
			assign rx    = cx[i+1];
			assign ry    = cy[i+1];
			assign rmag  = cmag[i+1];
			assign rrank = crank[i+1];
		end

		pmas_cell #(
			.CW(CW)
		) u_cell (
			.clk       (clk),
			.occupied  (occ[i]),
			.load      (load),
			.shift     (shift),
			.left_flag (lflag),
			.new_x     (nx),
			.new_y     (ny),
			.new_mag   (nmag),
			.new_rank  (nrank),
			.left_x    (lx),
			.left_y    (ly),
			.left_mag  (lmag),
			.left_rank (lrank),
			.right_x   (rx),
			.right_y   (ry),
			.right_mag (rmag),
			.right_rank(rrank),
			.x         (cx[i]),
			.y         (cy[i]),
			.mag       (cmag[i]),
			.rank      (crank[i]),
			.flag      (flags[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (pop) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
						if (nlast) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (shift) begin
						count_q <= count_q - 1'b1;
						if (count_q == CNTW'(1)) begin
							drop_q  <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_POINTS))
		else $error("point count exceeds capacity");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> count_q != '0)
		else $error("result offered from an empty store");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (full || result_valid))
		else $error("drop flag set while store not full");

	a_set_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(shift && result.last_out) |=> (count_q == '0 && !drop_q && !result_valid))
		else $error("store not cleared after final item");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/point_magnitude_angle_sorter.sv =====
// Load: one point per clock when not stalled, set by the broadcast insertion-cell compare.
// Last point accepted to first sorted result: through front stage, queue and insert cells.
// Drain: one result per clock while result_stall is low; no point is inserted meanwhile.
// Reset clears the front stage, the queue pointers, the point count and the drop flag.
// Cell contents are undefined after reset and are read only below the point count.
`default_nettype none

module point_magnitude_angle_sorter #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 point_valid,
	output logic                 point_stall,
	input  pmas_pkg::point_in_t  point,
	output logic                 result_valid,
	input  logic                 result_stall,
	output pmas_pkg::point_out_t result
);
	import pmas_pkg::*;

	localparam int QW = 4 * COORD_BITS + 3;

	q_status_t        q_status;
	logic             push;
	logic             pop;
	logic [QW-1:0]    entry;
	logic [QW-1:0]    head;

	pmas_front #(
		.CW(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.point      (point),
		.q_status   (q_status),
		.push       (push),
		.entry      (entry)
	);

	pmas_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.entry   (entry),
		.pop     (pop),
		.head    (head),
		.q_status(q_status)
	);

	pmas_back #(
		.MAX_POINTS(MAX_POINTS),
		.CW        (COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

`default_nettype wire
